// ===== hdl/eia_pkg.sv =====
`timescale 1ns / 1ps

package eia_pkg;

  // argument kinds on the input tuser
  localparam logic [1:0] CMD_MODULUS     = 2'd0;
  localparam logic [1:0] CMD_PARAM       = 2'd1;
  localparam logic [1:0] CMD_ANGLE       = 2'd2;
  localparam logic [1:0] CMD_MODULUS_ALT = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INFINITE = 2'd1;
  localparam logic [1:0] ST_DOMAIN   = 2'd2;

  localparam int MW   = 36;  // m, CORDIC registers (signed)
  localparam int AW   = 33;  // a, g, d
  localparam int OPW  = 34;  // multiplier operands
  localparam int PW   = 68;  // multiplier product
  localparam int ACCW = 54;  // E sum accumulator (signed)

  localparam logic signed [MW-1:0] ONE_S      = 36'sd1073741824;
  localparam logic signed [MW-1:0] PI_S       = 36'sd3373259426;
  localparam logic signed [MW-1:0] PI_HALF_S  = 36'sd1686629713;
  localparam logic signed [MW-1:0] GAIN_S     = 36'sd652032874;
  localparam logic [31:0]          PI_HALF_Q30    = 32'd1686629713;
  localparam logic [31:0]          PI_QUARTER_Q30 = 32'd843314857;
  localparam logic [31:0]          PI_HALF_Q24    = 32'd26353590;
  localparam logic [31:0]          ONE_Q30        = 32'd1073741824;

  localparam logic [4:0] CORDIC_LAST = 5'd29;
  localparam logic [4:0] STEP_LAST   = 5'd31;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_CORDIC, S_SABS, S_MMUL, S_MFORM, S_CHECK, S_SQRT, S_GSET,
    S_ROUND, S_RMUL1, S_RSQL, S_RACC, S_FIN, S_KDIV, S_KSET, S_ELOAD, S_EDIV,
    S_OUT
  } eia_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_CORDIC, OP_SABS, OP_MFORM, OP_CHECK,
    OP_SQRT_STEP, OP_GSET, OP_ROUND, OP_RMUL1, OP_RSQL, OP_RACC, OP_FIN,
    OP_DIV_STEP, OP_KSET, OP_ELOAD, OP_OUT
  } eia_op_e;

  typedef enum logic [1:0] {
    RES_NORMAL, RES_ZERO, RES_INF, RES_DOMAIN
  } eia_res_e;

  typedef struct packed {
    eia_op_e  op;
    logic [4:0] step;
    logic     mul_en;
    eia_res_e res;
  } eia_cmd_t;

  typedef struct packed {
    logic       x_zero;
    logic [1:0] kind;
    logic       m_above;
    logic       m_one;
    logic       d_small;
    logic [4:0] n;
    logic       out_busy;
  } eia_stat_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/eia_dp.sv =====
`timescale 1ns / 1ps

module eia_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eia_pkg::eia_cmd_t   cmd_i,
  output eia_pkg::eia_stat_t  stat_o,
  input  logic [31:0]         in_data_i,
  input  logic [1:0]          in_user_i,
  output logic [63:0]         out_data_o,
  output logic [1:0]          out_user_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  localparam int MW   = eia_pkg::MW;
  localparam int AW   = eia_pkg::AW;
  localparam int OPW  = eia_pkg::OPW;
  localparam int PW   = eia_pkg::PW;
  localparam int ACCW = eia_pkg::ACCW;

  logic [1:0]               kind_q;
  logic signed [31:0]       x_q;
  logic signed [MW-1:0]     cx_q, cy_q, z_q, m_q;
  logic [OPW-1:0]           op_a_q, op_b_q;
  logic [PW-1:0]            prod_q;
  logic [AW-1:0]            a_q, g_q, d_q;
  logic signed [ACCW-1:0]   acc_q;
  logic [4:0]               n_q;
  logic [63:0]              sq_rad_q;
  logic [32:0]              sq_root_q;
  logic [33:0]              sq_rem_q;
  logic [32:0]              dv_rem_q, dv_den_q;
  logic [31:0]              dv_quo_q;
  logic                     dv_sat_q;
  logic [31:0]              kq_q;
  logic [31:0]              ok_q, oe_q;
  logic [1:0]               ost_q;
  logic                     ovalid_q;

  // argument handling
  logic [31:0]          k_abs;
  logic signed [MW-1:0] z0, z_refl;
  assign k_abs = x_q[31] ? (32'd0 - 32'(x_q)) : 32'(x_q);
  assign z0    = MW'(x_q) <<< 1;
  always_comb begin
    if (z0 > eia_pkg::PI_HALF_S) begin
      z_refl = eia_pkg::PI_S - z0;
    end else if (z0 < -eia_pkg::PI_HALF_S) begin
      z_refl = -eia_pkg::PI_S - z0;
    end else begin
      z_refl = z0;
    end
  end

  // CORDIC rotation step
  logic signed [MW-1:0] dx, dy, at;
  assign dx = cy_q >>> cmd_i.step;
  assign dy = cx_q >>> cmd_i.step;
  assign at = MW'(eia_pkg::atan_q30(cmd_i.step));

  logic signed [MW-1:0] cy_abs;
  logic [30:0]          s_clamp;
  assign cy_abs  = cy_q[MW-1] ? -cy_q : cy_q;
  assign s_clamp = (cy_abs > eia_pkg::ONE_S) ? 31'(eia_pkg::ONE_Q30) : cy_abs[30:0];

  // m rounding from the squared argument
  logic [PW-1:0]        psum_k, psum_s;
  logic signed [MW-1:0] m_form;
  assign psum_k = prod_q + (PW'(1) << 27);
  assign psum_s = prod_q + (PW'(1) << 29);
  assign m_form = (kind_q == eia_pkg::CMD_ANGLE) ? psum_s[65:30] : psum_k[63:28];

  logic signed [MW-1:0] one_minus;
  assign one_minus = eia_pkg::ONE_S - m_q;

  // square root step: two radicand bits per cycle
  logic [35:0] rem_sh, trial;
  assign rem_sh = {sq_rem_q, sq_rad_q[63:62]};
  assign trial  = {1'b0, sq_root_q, 2'b01};

  // AGM round
  logic [AW:0]   ag_sum;
  logic [AW-1:0] d_abs;
  assign ag_sum = {1'b0, a_q} + {1'b0, g_q};
  assign d_abs  = (a_q > g_q) ? (a_q - g_q) : (g_q - a_q);

  // round n (counted from one) weighs c^2 by 2^n
  logic [PW-1:0]      c2_sum;
  logic [ACCW-1:0]    c2_sh;
  assign c2_sum = prod_q + (PW'(1) << 31);
  assign c2_sh  = ACCW'(c2_sum[63:32]) << (n_q + 5'd1);

  logic [OPW-1:0] acc_clamp;
  assign acc_clamp = acc_q[ACCW-1] ? '0 : acc_q[OPW-1:0];

  // division: quotient saturates when num >= den * 2^32
  logic [63:0] num_k, num_e, num_sel;
  logic [32:0] den_sel;
  logic [33:0] r2;
  assign num_k   = (64'(eia_pkg::PI_HALF_Q30) << 24) + 64'(g_q >> 1);
  assign num_e   = prod_q[63:0] + 64'(a_q >> 1);
  assign num_sel = (cmd_i.op == eia_pkg::OP_FIN) ? num_k : num_e;
  assign den_sel = (cmd_i.op == eia_pkg::OP_FIN) ? g_q : a_q;
  assign r2      = {dv_rem_q, dv_quo_q[31]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PW'(op_a_q) * PW'(op_b_q);
    end
    case (cmd_i.op)
      eia_pkg::OP_LOAD: begin
        kind_q <= in_user_i;
        x_q    <= signed'(in_data_i);
      end
      eia_pkg::OP_PREP: begin
        m_q    <= z0;
        cx_q   <= eia_pkg::GAIN_S;
        cy_q   <= '0;
        z_q    <= z_refl;
        op_a_q <= OPW'(k_abs);
        op_b_q <= OPW'(k_abs);
      end
      eia_pkg::OP_CORDIC: begin
        if (z_q >= 0) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + at;
        end
      end
      eia_pkg::OP_SABS: begin
        op_a_q <= OPW'(s_clamp);
        op_b_q <= OPW'(s_clamp);
      end
      eia_pkg::OP_MFORM: m_q <= m_form;
      eia_pkg::OP_CHECK: begin
        sq_rad_q  <= {one_minus[33:0], 30'd0};
        sq_root_q <= '0;
        sq_rem_q  <= '0;
        acc_q     <= (ACCW'(signed'(eia_pkg::ONE_S)) <<< 1) - ACCW'(m_q);
        a_q       <= AW'(eia_pkg::ONE_Q30);
        n_q       <= '0;
      end
      eia_pkg::OP_SQRT_STEP: begin
        if (rem_sh >= trial) begin
          sq_rem_q  <= 34'(rem_sh - trial);
          sq_root_q <= {sq_root_q[31:0], 1'b1};
        end else begin
          sq_rem_q  <= rem_sh[33:0];
          sq_root_q <= {sq_root_q[31:0], 1'b0};
        end
        sq_rad_q <= {sq_rad_q[61:0], 2'b00};
      end
      eia_pkg::OP_GSET: g_q <= sq_root_q;
      eia_pkg::OP_ROUND: begin
        op_a_q <= OPW'(a_q);
        op_b_q <= OPW'(g_q);
        d_q    <= d_abs;
        a_q    <= ag_sum[AW:1];
      end
      eia_pkg::OP_RMUL1: begin
        op_a_q <= OPW'(d_q);
        op_b_q <= OPW'(d_q);
      end
      eia_pkg::OP_RSQL: begin
        sq_rad_q  <= prod_q[63:0];
        sq_root_q <= '0;
        sq_rem_q  <= '0;
      end
      eia_pkg::OP_RACC: begin
        acc_q <= acc_q - signed'(c2_sh);
        n_q   <= n_q + 5'd1;
      end
      eia_pkg::OP_FIN, eia_pkg::OP_ELOAD: begin
        if (cmd_i.op == eia_pkg::OP_FIN) begin
          op_a_q <= OPW'(eia_pkg::PI_QUARTER_Q30);
          op_b_q <= acc_clamp;
        end
        dv_sat_q <= {1'b0, num_sel[63:32]} >= den_sel;
        dv_rem_q <= {1'b0, num_sel[63:32]};
        dv_quo_q <= num_sel[31:0];
        dv_den_q <= den_sel;
      end
      eia_pkg::OP_DIV_STEP: begin
        if (r2 >= {1'b0, dv_den_q}) begin
          dv_rem_q <= 33'(r2 - {1'b0, dv_den_q});
          dv_quo_q <= {dv_quo_q[30:0], 1'b1};
        end else begin
          dv_rem_q <= r2[32:0];
          dv_quo_q <= {dv_quo_q[30:0], 1'b0};
        end
      end
      eia_pkg::OP_KSET: kq_q <= dv_sat_q ? '1 : dv_quo_q;
      eia_pkg::OP_OUT: begin
        case (cmd_i.res)
          eia_pkg::RES_ZERO: begin
            ok_q  <= eia_pkg::PI_HALF_Q24;
            oe_q  <= eia_pkg::PI_HALF_Q30;
            ost_q <= eia_pkg::ST_OK;
          end
          eia_pkg::RES_INF: begin
            ok_q  <= '1;
            oe_q  <= eia_pkg::ONE_Q30;
            ost_q <= eia_pkg::ST_INFINITE;
          end
          eia_pkg::RES_DOMAIN: begin
            ok_q  <= '0;
            oe_q  <= '0;
            ost_q <= eia_pkg::ST_DOMAIN;
          end
          default: begin
            ok_q  <= kq_q;
            oe_q  <= dv_sat_q ? '1 : dv_quo_q;
            ost_q <= eia_pkg::ST_OK;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.op == eia_pkg::OP_OUT) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_data_o  = {oe_q, ok_q};
  assign out_user_o  = ost_q;
  assign out_valid_o = ovalid_q;

  assign stat_o.x_zero   = (x_q == 32'sd0);
  assign stat_o.kind     = kind_q;
  assign stat_o.m_above  = (m_q > eia_pkg::ONE_S);
  assign stat_o.m_one    = (m_q == eia_pkg::ONE_S);
  assign stat_o.d_small  = (d_q <= AW'(1));
  assign stat_o.n        = n_q;
  assign stat_o.out_busy = ovalid_q && !out_ready_i;

endmodule

// ===== hdl/eia_ctrl.sv =====
`timescale 1ns / 1ps

module eia_ctrl #(
  parameter int MAX_ITER = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  eia_pkg::eia_stat_t  stat_i,
  output eia_pkg::eia_cmd_t   cmd_o
);

  eia_pkg::eia_state_e state_q, state_d;
  eia_pkg::eia_res_e   res_q, res_d;
  logic [4:0]          step_q, step_d;

  logic stepping;
  assign stepping = (state_q == eia_pkg::S_CORDIC) || (state_q == eia_pkg::S_SQRT) ||
                    (state_q == eia_pkg::S_KDIV) || (state_q == eia_pkg::S_EDIV);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      eia_pkg::S_IDLE: if (in_valid_i) state_d = eia_pkg::S_PREP;
      eia_pkg::S_PREP: begin
        if (stat_i.x_zero) begin
          state_d = eia_pkg::S_OUT;
          res_d   = eia_pkg::RES_ZERO;
        end else if (stat_i.kind == eia_pkg::CMD_ANGLE) begin
          state_d = eia_pkg::S_CORDIC;
        end else if (stat_i.kind == eia_pkg::CMD_PARAM) begin
          state_d = eia_pkg::S_CHECK;
        end else begin
          state_d = eia_pkg::S_MMUL;
        end
      end
      eia_pkg::S_CORDIC: if (step_q == eia_pkg::CORDIC_LAST) state_d = eia_pkg::S_SABS;
      eia_pkg::S_SABS:   state_d = eia_pkg::S_MMUL;
      eia_pkg::S_MMUL:   state_d = eia_pkg::S_MFORM;
      eia_pkg::S_MFORM:  state_d = eia_pkg::S_CHECK;
      eia_pkg::S_CHECK: begin
        if (stat_i.m_above) begin
          state_d = eia_pkg::S_OUT;
          res_d   = eia_pkg::RES_DOMAIN;
        end else if (stat_i.m_one) begin
          state_d = eia_pkg::S_OUT;
          res_d   = eia_pkg::RES_INF;
        end else begin
          state_d = eia_pkg::S_SQRT;
          res_d   = eia_pkg::RES_NORMAL;
        end
      end
      eia_pkg::S_SQRT: if (step_q == eia_pkg::STEP_LAST) state_d = eia_pkg::S_GSET;
      eia_pkg::S_GSET: begin
        // first pass is the initial g; later passes end a round
        if (stat_i.n != 5'd0 && (stat_i.d_small || stat_i.n == 5'(MAX_ITER))) begin
          state_d = eia_pkg::S_FIN;
        end else begin
          state_d = eia_pkg::S_ROUND;
        end
      end
      eia_pkg::S_ROUND: state_d = eia_pkg::S_RMUL1;
      eia_pkg::S_RMUL1: state_d = eia_pkg::S_RSQL;
      eia_pkg::S_RSQL:  state_d = eia_pkg::S_RACC;
      eia_pkg::S_RACC:  state_d = eia_pkg::S_SQRT;
      eia_pkg::S_FIN:   state_d = eia_pkg::S_KDIV;
      eia_pkg::S_KDIV:  if (step_q == eia_pkg::STEP_LAST) state_d = eia_pkg::S_KSET;
      eia_pkg::S_KSET:  state_d = eia_pkg::S_ELOAD;
      eia_pkg::S_ELOAD: state_d = eia_pkg::S_EDIV;
      eia_pkg::S_EDIV:  if (step_q == eia_pkg::STEP_LAST) state_d = eia_pkg::S_OUT;
      eia_pkg::S_OUT:   if (!stat_i.out_busy) state_d = eia_pkg::S_IDLE;
      default:          state_d = eia_pkg::S_IDLE;
    endcase
    step_d = (stepping && state_d == state_q) ? step_q + 5'd1 : 5'd0;
  end

  always_comb begin
    cmd_o.op     = eia_pkg::OP_NONE;
    cmd_o.step   = step_q;
    cmd_o.mul_en = 1'b0;
    cmd_o.res    = res_q;
    in_ready_o   = 1'b0;
    case (state_q)
      eia_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = eia_pkg::OP_LOAD;
      end
      eia_pkg::S_PREP:   cmd_o.op = eia_pkg::OP_PREP;
      eia_pkg::S_CORDIC: cmd_o.op = eia_pkg::OP_CORDIC;
      eia_pkg::S_SABS:   cmd_o.op = eia_pkg::OP_SABS;
      eia_pkg::S_MMUL:   cmd_o.mul_en = 1'b1;
      eia_pkg::S_MFORM:  cmd_o.op = eia_pkg::OP_MFORM;
      eia_pkg::S_CHECK:  cmd_o.op = eia_pkg::OP_CHECK;
      eia_pkg::S_SQRT:   cmd_o.op = eia_pkg::OP_SQRT_STEP;
      eia_pkg::S_GSET:   cmd_o.op = eia_pkg::OP_GSET;
      eia_pkg::S_ROUND:  cmd_o.op = eia_pkg::OP_ROUND;
      eia_pkg::S_RMUL1: begin
        cmd_o.op     = eia_pkg::OP_RMUL1;
        cmd_o.mul_en = 1'b1;
      end
      eia_pkg::S_RSQL: begin
        cmd_o.op     = eia_pkg::OP_RSQL;
        cmd_o.mul_en = 1'b1;
      end
      eia_pkg::S_RACC:   cmd_o.op = eia_pkg::OP_RACC;
      eia_pkg::S_FIN:    cmd_o.op = eia_pkg::OP_FIN;
      eia_pkg::S_KDIV: begin
        cmd_o.op     = eia_pkg::OP_DIV_STEP;
        cmd_o.mul_en = 1'b1;  // pi/4 * sum, ready for the E division
      end
      eia_pkg::S_KSET:   cmd_o.op = eia_pkg::OP_KSET;
      eia_pkg::S_ELOAD:  cmd_o.op = eia_pkg::OP_ELOAD;
      eia_pkg::S_EDIV:   cmd_o.op = eia_pkg::OP_DIV_STEP;
      eia_pkg::S_OUT:    if (!stat_i.out_busy) cmd_o.op = eia_pkg::OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eia_pkg::S_IDLE;
      res_q   <= eia_pkg::RES_NORMAL;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      step_q  <= step_d;
    end
  end

  // round count is only meaningful once the first g is set
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eia_pkg::S_GSET) |-> (stat_i.n <= 5'(MAX_ITER)))
    else $error("AGM round count beyond limit");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == eia_pkg::OP_OUT) |-> !stat_i.out_busy)
    else $error("result written over a pending beat");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == eia_pkg::S_PREP))
    else $error("accepted beat not prepared");

  a_cordic_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eia_pkg::S_CORDIC) |-> (step_q <= eia_pkg::CORDIC_LAST))
    else $error("CORDIC step past table");

endmodule

// ===== hdl/elliptic_integrals_agm.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | tdata (low bit up)                 | tuser
// s_axis   | in        | x_value[31:0] Q3.29                | cmd[1:0]
// m_axis   | out       | first_kind[31:0], second_kind[63:32] | status[1:0]
//
// One item at a time. An angle adds a CORDIC pass, and the AGM part grows with R,
// where R (1..MAX_ITER) is the number of AGM rounds; each round is bound by the
// square root, and K and E each take a divide. A zero argument goes straight to
// the output; m = 1 and m > 1 stop after the check, soonest for a parameter.
// Reset clears the controller and the output valid; no clearing pass.
// A new beat is accepted once the previous result sits in the output register.
module elliptic_integrals_agm #(
  parameter int MAX_ITER = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_value
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // first_kind, second_kind
  output logic [1:0]  m_axis_tuser    // status
);

  eia_pkg::eia_cmd_t  cmd;
  eia_pkg::eia_stat_t stat;

  eia_ctrl #(
    .MAX_ITER(MAX_ITER)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  eia_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready)
  );

endmodule

// ===== tb/agm_checker.sv =====
`timescale 1ns / 1ps

module agm_checker #(
  parameter int MAX_ITER = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_value
  input  logic [1:0]  s_axis_tuser,   // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // first_kind, second_kind
  input  logic [1:0]  m_axis_tuser,   // status
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] k_val;
    logic [31:0] e_val;
    logic [1:0]  status;
  } integral_t;

  integral_t integral_q[$];

  localparam longint Q30 = 64'd1073741824;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  // |sin| in Q30 by rotation-mode CORDIC, clamped to one
  function automatic longint unsigned abs_sin(input longint z);
    longint cx, cy, dx, dy;
    cx = 64'sd652032874;
    cy = 0;
    if (z > 64'sd3373259426 / 2) z = 64'sd3373259426 - z;
    else if (z < -(64'sd3373259426 / 2)) z = -64'sd3373259426 - z;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(eia_pkg::atan_q30(5'(i)));
      end else begin
        cx += dx; cy -= dy; z += longint'(eia_pkg::atan_q30(5'(i)));
      end
    end
    if (cy < 0) cy = -cy;
    if (cy > Q30) cy = Q30;
    return cy;
  endfunction

  function automatic integral_t agm_integrals(input logic [1:0] kind, input logic [31:0] raw);
    integral_t r;
    longint xs, m, acc;
    longint unsigned a, g, kq, eq, s, k, ao, go, d, c2;
    xs = longint'(signed'(raw));
    if (xs == 0) return '{eia_pkg::PI_HALF_Q24, eia_pkg::PI_HALF_Q30, eia_pkg::ST_OK};
    if (kind == eia_pkg::CMD_PARAM) begin
      m = xs * 2;
    end else if (kind == eia_pkg::CMD_ANGLE) begin
      s = abs_sin(xs * 2);
      m = (s * s + (64'd1 << 29)) >> 30;
    end else begin
      k = xs < 0 ? -xs : xs;
      m = (k * k + (64'd1 << 27)) >> 28;
    end
    if (m > Q30) return '{32'd0, 32'd0, eia_pkg::ST_DOMAIN};
    if (m == Q30) return '{32'hFFFF_FFFF, eia_pkg::ONE_Q30, eia_pkg::ST_INFINITE};
    a = Q30;
    g = isqrt((Q30 - m) << 30);
    acc = 2 * Q30 - m;
    for (int i = 0; i < MAX_ITER; i++) begin
      ao = a; go = g;
      d = ao > go ? ao - go : go - ao;
      a = (ao + go) >> 1;
      g = isqrt(ao * go);
      c2 = (d * d + (64'd1 << 31)) >> 32;
      acc -= longint'(c2 << (i + 1));
      if (d <= 1) break;
    end
    if (acc < 0) acc = 0;
    if (g == 0) kq = 64'hFFFF_FFFF;
    else kq = ((64'(eia_pkg::PI_HALF_Q30) << 24) + (g >> 1)) / g;
    if (kq > 64'hFFFF_FFFF) kq = 64'hFFFF_FFFF;
    if (a == 0) eq = 64'hFFFF_FFFF;
    else eq = (64'(eia_pkg::PI_QUARTER_Q30) * acc + (a >> 1)) / a;
    if (eq > 64'hFFFF_FFFF) eq = 64'hFFFF_FFFF;
    r.k_val = kq[31:0];
    r.e_val = eq[31:0];
    r.status = eia_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    integral_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        integral_q.push_back(agm_integrals(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (integral_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          want = integral_q.pop_front();
          if (m_axis_tdata[31:0] !== want.k_val)
            report_mismatch("K", m_axis_tdata[31:0], want.k_val);
          if (m_axis_tdata[63:32] !== want.e_val)
            report_mismatch("E", m_axis_tdata[63:32], want.e_val);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", m_axis_tuser, want.status);
        end
      end
      pending_o = integral_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // x_value
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // first_kind, second_kind
  logic [1:0]  m_axis_tuser;        // status
  int          errors;
  int          pending;
  bit          hold_sink = 1'b0;

  always #6 clk_i = ~clk_i;

  elliptic_integrals_agm #(.MAX_ITER(8)) dut (.*);

  agm_checker #(.MAX_ITER(8)) checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(4);
    return $urandom_range(300, 40);
  endfunction

  // valid stays up across back-to-back beats; it drops only for a gap
  task automatic send_beat(input logic [1:0] kind, input logic [31:0] x);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_arg(input logic [1:0] kind);
    int p;
    p = $urandom_range(9);
    if (p == 0) return $urandom();
    if (kind == eia_pkg::CMD_PARAM)
      return p < 3 ? $urandom_range(32'h2000_0000, 32'h1FF0_0000)
                   : 32'($urandom_range(32'h1FFF_FFFF)) - 32'h1000_0000;
    if (kind == eia_pkg::CMD_ANGLE)
      return 32'($urandom_range(32'h6000_0000)) - 32'h3000_0000;
    return 32'($urandom_range(32'h4000_0000)) - 32'h2000_0000;
  endfunction

  // sink: random stalls, with a long hold-off on each request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [1:0] kind;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // extremes and special cases
    for (int c = 0; c < 4; c++) send_beat(2'(c), 32'd0);
    send_beat(eia_pkg::CMD_PARAM, 32'h2000_0000);       // m exactly one
    send_beat(eia_pkg::CMD_MODULUS, 32'h2000_0000);     // k = 1
    send_beat(eia_pkg::CMD_MODULUS, 32'hE000_0000);     // k = -1
    send_beat(eia_pkg::CMD_PARAM, 32'h2000_0001);       // just above one
    send_beat(eia_pkg::CMD_PARAM, 32'h1FFF_FFFF);       // m just below one
    send_beat(eia_pkg::CMD_PARAM, 32'h7FFF_FFFF);
    send_beat(eia_pkg::CMD_PARAM, 32'h8000_0000);       // very negative m
    send_beat(eia_pkg::CMD_MODULUS, 32'h7FFF_FFFF);
    send_beat(eia_pkg::CMD_MODULUS, 32'h8000_0000);
    send_beat(eia_pkg::CMD_ANGLE, 32'h3243_F6A9);       // pi/2
    send_beat(eia_pkg::CMD_ANGLE, 32'hCDBC_0957);       // -pi/2
    send_beat(eia_pkg::CMD_ANGLE, 32'h7FFF_FFFF);
    send_beat(eia_pkg::CMD_ANGLE, 32'h8000_0000);
    send_beat(eia_pkg::CMD_PARAM, 32'h0000_0001);
    send_beat(eia_pkg::CMD_PARAM, 32'hFFFF_FFFF);
    send_beat(eia_pkg::CMD_MODULUS_ALT, 32'h1000_0000);
    send_beat(eia_pkg::CMD_MODULUS_ALT, 32'hFFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    // sender pause until the checker has no pending results
    while (pending != 0) @(negedge clk_i);
    hold_sink = 1'b1;
    for (int i = 0; i < 1200; i++) begin
      kind = 2'($urandom_range(3));
      send_beat(kind, rand_arg(kind));
      if (i == 600) hold_sink = 1'b1;
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
